/* design/tick_task_scheduler_table_core_defines.svh */
// assertion macros for the scheduler table core
`ifndef TICK_TASK_SCHEDULER_TABLE_CORE_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TTS_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define TTS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define TTS_ASSERT_SAME(lbl, pre, post, msg)
`define TTS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* design/tts_pkg.sv */
package tts_pkg;

   // most run results one dispatch beat may cause
   localparam int MAX_OUT = 16;
   localparam int CNT_W   = 5;

   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_ADD      = 2'd1;
   localparam logic [1:0] MODE_DISPATCH = 2'd2;
   localparam logic [1:0] MODE_DELETE   = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_RUN    = 3'd2;
   localparam logic [2:0] ST_NONE   = 3'd3;
   localparam logic [2:0] ST_BADIDX = 3'd4;

   localparam logic [7:0] PENDING_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]  mode;
      logic [4:0]  slot_index;
      logic [15:0] start_delay;
      logic [15:0] repeat_period;
   } req_type;

   typedef struct packed {
      logic [4:0] result_slot;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] delay;
      logic [15:0] period;
      logic [7:0]  pending;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SINGLE,
      S_WALK
   } state_type;

endpackage

/* design/tts_slot_ram.sv */
module tts_slot_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tts_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output tts_pkg::entry_type  rd_data
);
   import tts_pkg::*;

   entry_type slot_mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tick_task_scheduler_table_core.sv */
// channel | ports                          | beat moves
// --------+--------------------------------+----------------------------------------
// request | req_valid req_ready req_data   | mode, slot_index, start_delay, period
// result  | rsp_valid rsp_ready rsp_data   | result_slot, status, last
//
// add, delete and a dispatch with nothing ready load the result register from the single state
// tick walks every slot of the slot memory, then the single state loads the result register
// dispatch walks one slot a cycle through the read and modify stages,
// and the walk pauses while a result waits on rsp_ready
// synchronous active-high reset clears valid and ready bits, walk state and rsp_valid only
// one beat is worked at a time; a new request is taken while the last result still waits
`include "tick_task_scheduler_table_core_defines.svh"

module tick_task_scheduler_table_core #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tts_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tts_pkg::rsp_type  rsp_data
);
   import tts_pkg::*;

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam logic [4:0]    NONE_CODE = 5'(NUM_SLOTS);
   localparam logic [CW-1:0] SCAN_END  = CW'(NUM_SLOTS);

   // control state
   state_type              state_ff, state_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;   // slot holds a task
   logic [NUM_SLOTS-1:0]   ready_ff, ready_in;   // slot has pending runs
   logic [CW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   proc_valid_ff, proc_valid_in;
   logic [IW-1:0]          proc_idx_ff, proc_idx_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // payload
   req_type                item_ff, item_in;
   rsp_type                rsp_ff, rsp_in;

   // slot memory port
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   entry_type              rd_data;
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   entry_type              wr_data;

   entry_type              tick_entry;
   entry_type              disp_entry;
   logic                   free_found;
   logic [IW-1:0]          free_idx;
   logic                   more_ready;

   logic                   accept;
   logic                   out_free;
   logic                   is_tick;
   logic                   walk_emit;
   logic                   walk_last;
   logic                   stall;
   logic                   scan_done;
   logic                   del_bad;

   tts_slot_ram #(
      .DEPTH (NUM_SLOTS),
      .AW    (IW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshake and walk conditions
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_tick   = (item_ff.mode == MODE_TICK);

   // a dispatch walk only reports slots that still owe runs
   assign walk_emit = (state_ff == S_WALK) && proc_valid_ff &&
                      (item_ff.mode == MODE_DISPATCH) && ready_ff[proc_idx_ff];
   assign stall     = walk_emit && !out_free;
   assign walk_last = walk_emit &&
                      ((cnt_ff == CNT_W'(MAX_OUT - 1)) || !more_ready);
   assign scan_done = (rd_idx_ff == SCAN_END) && !proc_valid_ff;
   assign del_bad   = ({1'b0, item_ff.slot_index} >= 6'(NUM_SLOTS));

   // lowest free slot for add
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   // any ready slot above the one in hand decides the last flag
   always_comb begin
      more_ready = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (ready_ff[i] && (i > int'(proc_idx_ff))) begin
            more_ready = 1'b1;
         end
      end
   end

   // tick update of one slot
   always_comb begin
      tick_entry = rd_data;
      if (rd_data.delay == '0) begin
         if (rd_data.pending != PENDING_MAX) begin
            tick_entry.pending = rd_data.pending + 8'd1;
         end
         if (rd_data.period != '0) begin
            tick_entry.delay = rd_data.period;
         end
      end else begin
         tick_entry.delay = rd_data.delay - 16'd1;
      end
   end

   // dispatch update of one slot
   always_comb begin
      disp_entry         = rd_data;
      disp_entry.pending = rd_data.pending - 8'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_TICK) begin
                  state_in = S_WALK;
               end else if (req_data.mode == MODE_DISPATCH && ready_ff != '0) begin
                  state_in = S_WALK;
               end else begin
                  state_in = S_SINGLE;
               end
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (walk_last && !stall) begin
               state_in = S_IDLE;
            end else if (scan_done) begin
               state_in = is_tick ? S_SINGLE : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in       = item_ff;
      valid_in      = valid_ff;
      ready_in      = ready_ff;
      rd_idx_in     = rd_idx_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[IW-1:0];
      wr_en         = 1'b0;
      wr_addr       = proc_idx_ff;
      wr_data       = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in       = req_data;
               rd_idx_in     = '0;
               proc_valid_in = 1'b0;
               cnt_in        = '0;
            end
         end

         S_WALK: begin
            if (!stall) begin
               // read stage: fetch the next slot
               if (rd_idx_ff != SCAN_END) begin
                  rd_en         = 1'b1;
                  proc_idx_in   = rd_idx_ff[IW-1:0];
                  proc_valid_in = 1'b1;
                  rd_idx_in     = rd_idx_ff + CW'(1);
               end else begin
                  proc_valid_in = 1'b0;
               end

               // modify stage: write back the slot the read stage fetched
               if (proc_valid_ff) begin
                  if (is_tick) begin
                     if (valid_ff[proc_idx_ff]) begin
                        wr_en   = 1'b1;
                        wr_data = tick_entry;
                        if (rd_data.delay == '0) begin
                           ready_in[proc_idx_ff] = 1'b1;
                        end
                     end
                  end else if (walk_emit) begin
                     wr_en   = 1'b1;
                     wr_data = disp_entry;
                     if (rd_data.period == '0) begin
                        // one-shot task leaves the table
                        valid_in[proc_idx_ff] = 1'b0;
                        ready_in[proc_idx_ff] = 1'b0;
                     end else begin
                        ready_in[proc_idx_ff] = (disp_entry.pending != '0);
                     end
                     rsp_valid_in       = 1'b1;
                     rsp_in.result_slot = 5'(proc_idx_ff);
                     rsp_in.status      = ST_RUN;
                     rsp_in.last        = walk_last;
                     cnt_in             = cnt_ff + CNT_W'(1);
                  end
               end
            end
         end

         S_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.last  = 1'b1;
               case (item_ff.mode)
                  MODE_TICK: begin
                     rsp_in.result_slot = NONE_CODE;
                     rsp_in.status      = ST_OK;
                  end
                  MODE_ADD: begin
                     if (free_found) begin
                        valid_in[free_idx] = 1'b1;
                        ready_in[free_idx] = 1'b0;
                        wr_en              = 1'b1;
                        wr_addr            = free_idx;
                        wr_data.delay      = item_ff.start_delay;
                        wr_data.period     = item_ff.repeat_period;
                        wr_data.pending    = '0;
                        rsp_in.result_slot = 5'(free_idx);
                        rsp_in.status      = ST_OK;
                     end else begin
                        rsp_in.result_slot = NONE_CODE;
                        rsp_in.status      = ST_FULL;
                     end
                  end
                  MODE_DISPATCH: begin
                     rsp_in.result_slot = NONE_CODE;
                     rsp_in.status      = ST_NONE;
                  end
                  MODE_DELETE: begin
                     if (del_bad) begin
                        rsp_in.result_slot = NONE_CODE;
                        rsp_in.status      = ST_BADIDX;
                     end else begin
                        // cleared bits make the stale entry read as empty
                        valid_in[item_ff.slot_index[IW-1:0]] = 1'b0;
                        ready_in[item_ff.slot_index[IW-1:0]] = 1'b0;
                        rsp_in.result_slot = item_ff.slot_index;
                        rsp_in.status      = ST_OK;
                     end
                  end
                  default: begin
                     rsp_in.result_slot = NONE_CODE;
                     rsp_in.status      = ST_OK;
                  end
               endcase
            end
         end

         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         ready_ff      <= '0;
         rd_idx_ff     <= '0;
         proc_valid_ff <= 1'b0;
         proc_idx_ff   <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         ready_ff      <= ready_in;
         rd_idx_ff     <= rd_idx_in;
         proc_valid_ff <= proc_valid_in;
         proc_idx_ff   <= proc_idx_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a slot with pending runs always holds a task
   `TTS_ASSERT_SAME(a_ready_in_valid, 1'b1, (ready_ff & ~valid_ff) == '0, "ready slot not valid")

   // a stalled dispatch result keeps its slot in the modify stage
   `TTS_ASSERT_NEXT(a_stall_hold, stall, $stable(proc_idx_ff) && proc_valid_ff, "stall lost slot")

   // one dispatch never reports more than the result limit
   `TTS_ASSERT_SAME(a_disp_bound, walk_emit, cnt_ff < CNT_W'(MAX_OUT), "dispatch over limit")

endmodule

/* dv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tts_pkg::*;

   localparam int NUM_SLOTS = 16;
   // slot code returned when no slot applies
   localparam logic [4:0] NONE_SLOT = 5'(NUM_SLOTS);

   // shadow of the slot table plus the queue of results it predicts
   class schedule_check;
      bit          used [NUM_SLOTS];
      bit   [15:0] countdown [NUM_SLOTS];
      bit   [15:0] reload [NUM_SLOTS];
      bit   [7:0]  owed [NUM_SLOTS];
      rsp_type     expected_results [$];
      int          mismatches;
      int          results_seen;

      function void report(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endfunction

      function void queue_result(logic [4:0] slot, logic [2:0] st, logic lst);
         expected_results.push_back('{result_slot: slot, status: st, last: lst});
      endfunction

      function void release_slot(int i);
         used[i]      = 1'b0;
         countdown[i] = '0;
         owed[i]      = '0;
      endfunction

      // advance the shadow table by one request beat
      function void take_request(req_type r);
         int runs;
         int slot;
         runs = 0;
         slot = -1;
         case (r.mode)
            MODE_TICK: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (used[i]) begin
                     if (countdown[i] == 16'd0) begin
                        if (owed[i] != PENDING_MAX) owed[i]++;
                        if (reload[i] != 16'd0) countdown[i] = reload[i];
                     end else begin
                        countdown[i]--;
                     end
                  end
               end
               queue_result(NONE_SLOT, ST_OK, 1'b1);
            end
            MODE_ADD: begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (!used[i] && slot < 0) slot = i;
               if (slot < 0) begin
                  queue_result(NONE_SLOT, ST_FULL, 1'b1);
               end else begin
                  used[slot]      = 1'b1;
                  countdown[slot] = r.start_delay;
                  reload[slot]    = r.repeat_period;
                  owed[slot]      = '0;
                  queue_result(5'(slot), ST_OK, 1'b1);
               end
            end
            MODE_DISPATCH: begin
               for (int i = 0; i < NUM_SLOTS && runs < MAX_OUT; i++) begin
                  if (owed[i] != 8'd0) begin
                     queue_result(5'(i), ST_RUN, 1'b0);
                     runs++;
                     owed[i]--;
                     if (reload[i] == 16'd0) release_slot(i);
                  end
               end
               if (runs == 0) queue_result(NONE_SLOT, ST_NONE, 1'b1);
               else expected_results[expected_results.size() - 1].last = 1'b1;
            end
            default: begin
               if (r.slot_index >= NUM_SLOTS) begin
                  queue_result(NONE_SLOT, ST_BADIDX, 1'b1);
               end else begin
                  release_slot(int'(r.slot_index));
                  queue_result(r.slot_index, ST_OK, 1'b1);
               end
            end
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result slot %0d status %0d last %0b",
                             got.result_slot, got.status, got.last));
            return;
         end
         want = expected_results.pop_front();
         if (got.result_slot !== want.result_slot)
            report($sformatf("result %0d: slot %0d, wanted %0d",
                             results_seen, got.result_slot, want.result_slot));
         if (got.status !== want.status)
            report($sformatf("result %0d: status %0d, wanted %0d",
                             results_seen, got.status, want.status));
         if (got.last !== want.last)
            report($sformatf("result %0d: last %0b, wanted %0b",
                             results_seen, got.last, want.last));
      endfunction
   endclass

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   schedule_check sched = new();
   int            items_sent;
   // set by the stimulus to make the result side hold off for a long stretch
   bit            hold_request;

   tick_task_scheduler_table_core #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // offer one request beat and hold it until taken, then maybe idle
   task automatic send_item(logic [1:0] mode, logic [4:0] idx,
                            logic [15:0] delay, logic [15:0] period);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, slot_index: idx, start_delay: delay,
                     repeat_period: period};
      do @(posedge clock); while (!req_ready);
      // the beat moved at this edge: predict what it causes
      sched.take_request('{mode: mode, slot_index: idx, start_delay: delay,
                           repeat_period: period});
      items_sent++;
      // every 32 beats, a run of 8 back to back
      gap = (items_sent % 32 < 8) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random beat: mostly short delays and periods so tasks actually come due
   task automatic send_random_item();
      int          pick;
      logic [1:0]  mode;
      logic [4:0]  idx;
      logic [15:0] delay;
      logic [15:0] period;
      pick   = $urandom_range(0, 99);
      idx    = 5'($urandom_range(0, 31));
      delay  = 16'($urandom);
      period = 16'($urandom);
      if (pick < 30) mode = MODE_ADD;
      else if (pick < 60) mode = MODE_TICK;
      else if (pick < 85) mode = MODE_DISPATCH;
      else mode = MODE_DELETE;
      // one add in eight keeps the full 16-bit delay and period
      if (mode == MODE_ADD && $urandom_range(0, 7) != 0) begin
         delay  = 16'($urandom_range(0, 3));
         period = ($urandom_range(0, 9) < 4) ? 16'd0 : 16'($urandom_range(1, 5));
      end
      // deletes mostly hit real slots, sometimes an index past the table
      if (mode == MODE_DELETE && $urandom_range(0, 4) != 0)
         idx = 5'($urandom_range(0, NUM_SLOTS - 1));
      send_item(mode, idx, delay, period);
   endtask

   // result side: random stalls, a stall-free stretch every 40 results, one long hold
   initial begin : result_side
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            // long hold so the result register fills and the input stalls
            hold_request = 1'b0;
            stall = 250;
         end else if (sched.results_seen % 40 < 10) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 19);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sched.check_result(rsp_data);
      end
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table: nothing ready, tick with no tasks
      send_item(MODE_DISPATCH, 5'd31, 16'hffff, 16'hffff);
      send_item(MODE_TICK, 5'd31, 16'hffff, 16'hffff);

      // fill all slots due now: one-shot, longest period, period 1, and a mixed pattern
      send_item(MODE_ADD, 5'd0, 16'd0, 16'd0);
      send_item(MODE_ADD, 5'd0, 16'd0, 16'hffff);
      for (int i = 2; i < NUM_SLOTS - 1; i++) send_item(MODE_ADD, 5'(i), 16'd0, 16'd1);
      send_item(MODE_ADD, 5'd0, 16'd0, 16'h5a5a);

      // every slot ready at once: a full 16-result dispatch, frees the one-shot
      send_item(MODE_TICK, 5'd0, 16'd0, 16'd0);
      send_item(MODE_DISPATCH, 5'd0, 16'd0, 16'd0);

      // refill the freed slot with the longest delay, then the table is full
      send_item(MODE_ADD, 5'd0, 16'hffff, 16'd0);
      send_item(MODE_ADD, 5'd0, 16'd3, 16'd3);

      // bad indexes, delete of a live slot, delete of a free slot
      send_item(MODE_DELETE, 5'd31, 16'd0, 16'd0);
      send_item(MODE_DELETE, 5'(NUM_SLOTS), 16'd0, 16'd0);
      send_item(MODE_DELETE, 5'd0, 16'd0, 16'd0);
      send_item(MODE_DELETE, 5'd0, 16'd0, 16'd0);

      send_item(MODE_TICK, 5'd0, 16'd0, 16'd0);
      send_item(MODE_DISPATCH, 5'd0, 16'd0, 16'd0);

      // random part, with one long hold-off on the result side early on
      hold_request = 1'b1;
      repeat (82) send_random_item();
      req_valid <= 1'b0;

      // drain, then give a tick walk time to show any stray beat
      while (sched.expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sched.mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
